// File: hw/rtl/mcad_pkg.sv
// Shared types and fixed widths for the multi-client averaging decimator.
// No dependencies; imported by multi_client_averaging_decimator_core and its bench.
`timescale 1ns / 1ps
`default_nettype none

package mcad_pkg;

  // field and state widths
  localparam int SMP_W    = 16;
  localparam int RATIO_W  = 11;
  localparam int CNT_W    = 11;
  localparam int SUM_W    = 27;
  localparam int CLIENT_W = 2;
  localparam int CFG_IDX_W = 2;

  // the quotient of a finished group always fits the sample width
  localparam int DIV_STEPS = SMP_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // offset-binary to two's complement
  localparam logic [SMP_W-1:0] AVG_OFFSET = 16'h8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_EMIT,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/multi_client_averaging_decimator_core.sv
// Top level of the multi-client averaging decimator: sequencer, group state
// and a shared bit-serial divider. Depends on mcad_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One offset-binary sample word feeds up to four client decimators. Each
// enabled client (nonzero ratio) adds the sample to its group sum; when the
// group holds ratio samples the client sends one word with sum/ratio - 32768
// and starts a new group. Result words of one sample come in ascending client
// order and the final one carries last. block_end drops every partial group
// after the marked sample has been counted. A ratio write clamps to MAX_RATIO
// and restarts that client's group; ratio writes belong between sample words,
// once the core is back in idle.
// Sequence per sample: idle, an accumulate step for each client, then a final
// step. Each client that completes a group adds a pass of the shared
// one-bit-per-cycle restoring divider and a load of the output register,
// which waits while the output side stalls.
module multi_client_averaging_decimator_core #(
  parameter int NUM_CLIENTS = 4,
  parameter int MAX_RATIO   = 1280
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [mcad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mcad_pkg::RATIO_W-1:0]   cfg_data,
  // sample input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mcad_pkg::SMP_W-1:0]     sample,
  input  wire logic                           block_end,
  // averaged output
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [mcad_pkg::CLIENT_W-1:0]       client,
  output logic signed [mcad_pkg::SMP_W-1:0]   average,
  output logic                                last
);

  import mcad_pkg::*;

  localparam int PW  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int REM_W = SUM_W - SMP_W;

  state_t state, state_next;

  // per-client configuration and group state
  logic [RATIO_W-1:0] ratio     [NUM_CLIENTS];
  logic [SUM_W-1:0]   group_sum [NUM_CLIENTS];
  logic [CNT_W-1:0]   group_cnt [NUM_CLIENTS];

  // current item
  logic [SMP_W-1:0]       smp;
  logic                   blk;
  logic [NUM_CLIENTS-1:0] mask;
  logic [PW-1:0]          ptr;

  // serial divider
  logic [REM_W-1:0]   rem;
  logic [SMP_W-1:0]   quo;
  logic [RATIO_W-1:0] div_ratio;
  logic [DCNT_W-1:0]  div_cnt;

  logic                   in_fire;
  logic                   out_free;
  logic                   last_client;
  logic                   emit_now;
  logic                   more_after;
  logic [NUM_CLIENTS-1:0] mask_now;
  logic [SUM_W-1:0]       acc_sum;
  logic [REM_W:0]         trial;
  logic                   trial_ge;
  logic [RATIO_W-1:0]     ratio_wr;
  logic                   cfg_hit;

  assign in_fire     = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign last_client = (ptr == PW'(NUM_CLIENTS - 1));
  assign emit_now    = mask[ptr];
  assign acc_sum     = group_sum[ptr] + SUM_W'(smp);
  assign trial       = {rem, quo[SMP_W-1]};
  assign trial_ge    = (trial >= {1'b0, div_ratio});

  // clients whose group completes with this sample
  always_comb begin
    for (int i = 0; i < NUM_CLIENTS; i++) begin
      mask_now[i] = (ratio[i] != '0) &&
                    (({1'b0, group_cnt[i]} + (CNT_W+1)'(1)) == {1'b0, ratio[i]});
    end
  end

  // any later client still to emit for this sample
  always_comb begin
    more_after = 1'b0;
    for (int j = 0; j < NUM_CLIENTS; j++) begin
      if (PW'(j) > ptr && mask[j]) begin
        more_after = 1'b1;
      end
    end
  end

  // ratio write clamp and decode
  assign ratio_wr = (32'(cfg_data) > MAX_RATIO) ? RATIO_W'(MAX_RATIO) : cfg_data;
  assign cfg_hit  = cfg_we && (32'(cfg_index) < NUM_CLIENTS);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        if (emit_now) begin
          state_next = ST_DIV;
        end else if (last_client) begin
          state_next = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_cnt == DCNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = last_client ? ST_FIN : ST_ACC;
        end
      end
      ST_FIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ptr       <= '0;
      div_cnt   <= '0;
      mask      <= '0;
      blk       <= 1'b0;
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        ratio[i]     <= '0;
        group_sum[i] <= '0;
        group_cnt[i] <= '0;
      end
    end else begin
      // output register empties unless a new word loads below
      if (out_valid && out_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        // capture the word and which groups it completes
        ST_IDLE: begin
          if (in_fire) begin
            smp  <= sample;
            blk  <= block_end;
            mask <= mask_now;
            ptr  <= '0;
          end
        end
        // one client per cycle, held while a finished group is divided and emitted
        ST_ACC: begin
          if (emit_now) begin
            rem            <= acc_sum[SUM_W-1:SMP_W];
            quo            <= acc_sum[SMP_W-1:0];
            div_ratio      <= ratio[ptr];
            div_cnt        <= '0;
            group_sum[ptr] <= '0;
            group_cnt[ptr] <= '0;
          end else begin
            if (ratio[ptr] != '0) begin
              group_sum[ptr] <= acc_sum;
              group_cnt[ptr] <= group_cnt[ptr] + CNT_W'(1);
            end
            if (!last_client) begin
              ptr <= ptr + PW'(1);
            end
          end
        end
        // restoring division, one quotient bit per cycle
        ST_DIV: begin
          rem     <= trial_ge ? REM_W'(trial - {1'b0, div_ratio}) : REM_W'(trial);
          quo     <= {quo[SMP_W-2:0], trial_ge};
          div_cnt <= div_cnt + DCNT_W'(1);
        end
        // hand the word to the output register
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            client    <= CLIENT_W'(ptr);
            average   <= quo - AVG_OFFSET;
            last      <= !more_after;
            if (!last_client) begin
              ptr <= ptr + PW'(1);
            end
          end
        end
        // drop partial groups at block end
        ST_FIN: begin
          if (blk) begin
            for (int i = 0; i < NUM_CLIENTS; i++) begin
              group_sum[i] <= '0;
              group_cnt[i] <= '0;
            end
          end
        end
        default: begin
        end
      endcase

      // ratio write restarts the client's group
      if (cfg_hit) begin
        ratio[PW'(cfg_index)]     <= ratio_wr;
        group_sum[PW'(cfg_index)] <= '0;
        group_cnt[PW'(cfg_index)] <= '0;
      end
    end
  end

`ifndef SYNTH
  // partial remainder stays below the divisor
  a_rem_below_ratio: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ({1'b0, rem} < {1'b0, div_ratio}))
    else $error("divider remainder not below ratio");

  // a disabled client 0 keeps an empty group
  a_disabled_empty: assert property (@(posedge clk) disable iff (rst)
    (ratio[0] == '0) |-> (group_sum[0] == '0 && group_cnt[0] == '0))
    else $error("disabled client holds a partial group");

  // between words the group count of client 0 stays below its ratio
  a_count_below_ratio: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && ratio[0] != '0) |-> (group_cnt[0] < ratio[0]))
    else $error("group count reached ratio while idle");

  // a result word is loaded only after a full division
  a_emit_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && $past(state) == ST_DIV) |->
      ($past(div_cnt) == DCNT_W'(DIV_STEPS - 1)))
    else $error("division cut short");
`endif

endmodule

`default_nettype wire

// File: bench/tb_multi_client_averaging_decimator_core.sv
// Self-checking bench for multi_client_averaging_decimator_core: directed and
// random sample words, per-client ratio settings and randomized flow control.
// Depends on mcad_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_multi_client_averaging_decimator_core;
  import mcad_pkg::*;

  localparam int NUM_CLIENTS = 4;
  localparam int MAX_RATIO   = 1280;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYC  = 100;
  localparam int CLAMP_WORDS = 8;

  // ratio register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_3 = 2'd3;

  typedef struct packed {
    logic [SMP_W-1:0] smp;
    logic             blk;
  } smp_word_t;

  typedef struct packed {
    logic [CLIENT_W-1:0]     cli;
    logic signed [SMP_W-1:0] avg;
    logic                    fin;
  } avg_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [RATIO_W-1:0]       cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [SMP_W-1:0]         sample    = '0;
  logic                     block_end = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [CLIENT_W-1:0]      client;
  logic signed [SMP_W-1:0]  average;
  logic                     last;

  multi_client_averaging_decimator_core #(
    .NUM_CLIENTS(NUM_CLIENTS),
    .MAX_RATIO  (MAX_RATIO)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sample   (sample),
    .block_end(block_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .client   (client),
    .average  (average),
    .last     (last)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mirror of the decimator state
  logic [RATIO_W-1:0] ratio_mirror [NUM_CLIENTS];
  logic [SUM_W-1:0]   group_sum_m  [NUM_CLIENTS];
  logic [CNT_W-1:0]   group_cnt_m  [NUM_CLIENTS];

  smp_word_t smp_pending [$];
  avg_word_t avg_expected [$];
  smp_word_t drv_word;
  bit        in_took = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        err_count = 0;
  int        cycle_count = 0;

  initial begin
    for (int i = 0; i < NUM_CLIENTS; i++) begin
      ratio_mirror[i] = '0;
      group_sum_m[i]  = '0;
      group_cnt_m[i]  = '0;
    end
  end

  // ratio write: clamp and restart that client's group
  function automatic void apply_ratio(logic [CFG_IDX_W-1:0] idx, logic [RATIO_W-1:0] val);
    logic [RATIO_W-1:0] r;
    r = (val > MAX_RATIO) ? RATIO_W'(MAX_RATIO) : val;
    ratio_mirror[idx] = r;
    group_sum_m[idx]  = '0;
    group_cnt_m[idx]  = '0;
  endfunction

  // accumulate one sample into every enabled client and queue finished averages
  function automatic void predict_averages(logic [SMP_W-1:0] smp, logic blk);
    avg_word_t        words [NUM_CLIENTS];
    logic [SUM_W-1:0] quot;
    int               n;
    n = 0;
    for (int i = 0; i < NUM_CLIENTS; i++) begin
      if (ratio_mirror[i] == '0) continue;
      group_sum_m[i] = group_sum_m[i] + SUM_W'(smp);
      group_cnt_m[i] = group_cnt_m[i] + CNT_W'(1);
      if (group_cnt_m[i] >= ratio_mirror[i]) begin
        quot           = group_sum_m[i] / SUM_W'(ratio_mirror[i]);
        words[n].cli   = CLIENT_W'(i);
        words[n].avg   = quot[SMP_W-1:0] - AVG_OFFSET;
        words[n].fin   = 1'b0;
        n++;
        group_sum_m[i] = '0;
        group_cnt_m[i] = '0;
      end
    end
    for (int k = 0; k < n; k++) begin
      words[k].fin = (k == n - 1);
      avg_expected.push_back(words[k]);
    end
    // block end drops partial groups after the sample was counted
    if (blk) begin
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        group_sum_m[i] = '0;
        group_cnt_m[i] = '0;
      end
    end
  endfunction

  // sample word driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (smp_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_word = smp_pending.pop_front();
        sample    <= drv_word.smp;
        block_end <= drv_word.blk;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accepted samples, check accepted averages
  always @(posedge clk) begin
    avg_word_t exp_w;
    in_took = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        predict_averages(sample, block_end);
      end
      if (out_valid && out_ready) begin
        if (avg_expected.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected word: client %0d average %0d last %0b",
                     client, average, last);
        end else begin
          exp_w = avg_expected.pop_front();
          if (client !== exp_w.cli || average !== exp_w.avg || last !== exp_w.fin) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: exp client %0d average %0d last %0b, got %0d %0d %0b",
                       exp_w.cli, exp_w.avg, exp_w.fin, client, average, last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_ratio(logic [CFG_IDX_W-1:0] idx, logic [RATIO_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_ratio(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_word(logic [SMP_W-1:0] smp, logic blk);
    smp_word_t w;
    w.smp = smp;
    w.blk = blk;
    smp_pending.push_back(w);
  endtask

  // wait until every word is in and every average is out, then let the core settle
  task automatic drain();
    while (smp_pending.size() != 0 || in_valid || avg_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic randomize_ratios();
    logic [RATIO_W-1:0] r;
    for (int i = 0; i < NUM_CLIENTS; i++) begin
      case ($urandom_range(11))
        0:       r = '0;
        1:       r = RATIO_W'(1);
        2:       r = '1;
        3:       r = RATIO_W'($urandom_range(40, 7));
        default: r = RATIO_W'($urandom_range(6, 1));
      endcase
      write_ratio(CFG_IDX_W'(i), r);
    end
  endtask

  // random words with extremes mixed in
  task automatic queue_random(int n, int blk_pct);
    logic [SMP_W-1:0] s;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(7))
        0:       s = '0;
        1:       s = '1;
        default: s = SMP_W'($urandom);
      endcase
      push_word(s, $urandom_range(99) < blk_pct);
    end
  endtask

  // stimulus
  initial begin
    int idle_tbl  [4];
    int stall_tbl [4];
    idle_tbl  = '{0, 75, 0, 16};
    stall_tbl = '{0, 0, 75, 16};
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // pass-through, pairs, triples, one client disabled
    write_ratio(REG_RATIO_0, RATIO_W'(1));
    write_ratio(REG_RATIO_1, RATIO_W'(2));
    write_ratio(REG_RATIO_2, RATIO_W'(3));
    write_ratio(REG_RATIO_3, '0);
    push_word(16'h0000, 1'b0);
    push_word(16'hFFFF, 1'b0);
    push_word(16'h8000, 1'b0);
    push_word(16'h7FFF, 1'b0);
    push_word(16'h0001, 1'b1);
    push_word(16'hFFFF, 1'b0);
    push_word(16'hFFFF, 1'b1);
    push_word(16'h8001, 1'b0);
    push_word(16'h1234, 1'b0);
    push_word(16'hFFFE, 1'b0);
    push_word(16'h5555, 1'b0);
    push_word(16'hAAAA, 1'b1);
    drain();

    // every client emits on each word
    write_ratio(REG_RATIO_0, RATIO_W'(1));
    write_ratio(REG_RATIO_1, RATIO_W'(1));
    write_ratio(REG_RATIO_2, RATIO_W'(1));
    write_ratio(REG_RATIO_3, RATIO_W'(1));
    push_word(16'h0000, 1'b0);
    push_word(16'hFFFF, 1'b1);
    push_word(16'h8000, 1'b0);
    push_word(16'h7FFF, 1'b0);
    drain();

    // clamped maximum ratio, near-full-scale samples fill part of a group
    write_ratio(REG_RATIO_0, '0);
    write_ratio(REG_RATIO_1, '0);
    write_ratio(REG_RATIO_2, '0);
    write_ratio(REG_RATIO_3, '1);
    for (int k = 0; k < CLAMP_WORDS; k++)
      push_word(SMP_W'($urandom_range(65535, 65280)), 1'b0);
    drain();

    // random phases over each flow-control mode
    for (int m = 0; m < 4; m++) begin
      for (int p = 0; p < 2; p++) begin
        randomize_ratios();
        send_idle_pct  = idle_tbl[m];
        recv_stall_pct = stall_tbl[m];
        queue_random(55, 8);
        drain();
      end
    end

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: multi_client_averaging_decimator_core.f
hw/rtl/mcad_pkg.sv
hw/rtl/multi_client_averaging_decimator_core.sv
bench/tb_multi_client_averaging_decimator_core.sv
